@@ hw/rtl/pcr_pkg.sv @@
// Package for the prime counter: field widths, parameter defaults,
// and the command and status structs between controller and datapath.
// Depends on nothing.
package pcr_pkg;

    localparam int FIELD_W        = 16;
    localparam int COUNT_W        = 17;
    localparam int VALUE_BITS_DEF = 16;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;
        logic cand_next;
        logic div_init;
        logic div_next;
        logic mod_init;
        logic mod_step;
        logic count_inc;
        logic publish;
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic empty;
        logic cand_small;
        logic last_cand;
        logic sq_gt;
        logic mod_last;
        logic rem_zero;
    } t_sts;

    // Operand width actually used: inputs are masked to the narrower of the two
    function automatic int op_width(input int vb);
        return (vb < FIELD_W) ? vb : FIELD_W;
    endfunction

endpackage

@@ hw/rtl/pcr_dp.sv @@
// Datapath of the prime counter: candidate, divisor and square, a
// bit-serial remainder unit, the running count and the output register.
// Depends on pcr_pkg.
module pcr_dp #(
    parameter int VALUE_BITS = pcr_pkg::VALUE_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic [pcr_pkg::FIELD_W-1:0]  i_range_low,
    input  logic [pcr_pkg::FIELD_W-1:0]  i_range_high,
    input  pcr_pkg::t_cmd                i_cmd,
    output pcr_pkg::t_sts                o_sts,
    output logic [pcr_pkg::COUNT_W-1:0]  o_prime_count
);
    import pcr_pkg::*;

    localparam int OP_W  = op_width(VALUE_BITS);
    localparam int D_W   = (OP_W + 1) / 2 + 1;
    localparam int SQ_W  = OP_W + 2;
    localparam int BC_W  = $clog2(OP_W);
    localparam int CNT_W = OP_W + 1;

    logic [OP_W-1:0]  r_cand;
    logic [OP_W-1:0]  r_hi;
    logic [D_W-1:0]   r_div;
    logic [SQ_W-1:0]  r_sq;
    logic [D_W-1:0]   r_rem;
    logic [BC_W-1:0]  r_bit;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_out;

    logic [D_W:0]     rem_sh;
    logic [D_W-1:0]   n_rem;

    // One restoring step: shift in the next candidate bit, subtract if it fits
    always_comb begin
        rem_sh = {r_rem, r_cand[r_bit]};
        if (rem_sh >= {1'b0, r_div}) begin
            n_rem = D_W'(rem_sh - {1'b0, r_div});
        end else begin
            n_rem = rem_sh[D_W-1:0];
        end
    end

    // Candidate, bound and count
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cand  <= i_range_low[OP_W-1:0];
            r_hi    <= i_range_high[OP_W-1:0];
            r_count <= '0;
        end else begin
            if (i_cmd.cand_next) begin
                r_cand <= r_cand + 1'b1;
            end
            if (i_cmd.count_inc) begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    // Divisor and its square, advanced by (d+1)^2 = d^2 + 2d + 1
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_div <= D_W'(2);
            r_sq  <= SQ_W'(4);
        end else if (i_cmd.div_next) begin
            r_div <= r_div + 1'b1;
            r_sq  <= r_sq + SQ_W'({r_div, 1'b1});
        end
    end

    // Remainder unit, one bit per cycle from the top
    always_ff @(posedge i_clk) begin
        if (i_cmd.mod_init) begin
            r_rem <= '0;
            r_bit <= BC_W'(OP_W - 1);
        end else if (i_cmd.mod_step) begin
            r_rem <= n_rem;
            r_bit <= r_bit - 1'b1;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.publish) begin
            r_out <= r_count;
        end
    end

    assign o_prime_count = COUNT_W'(r_out);

    assign o_sts.empty      = (r_cand > r_hi);
    assign o_sts.cand_small = (r_cand[OP_W-1:1] == '0);
    assign o_sts.last_cand  = (r_cand == r_hi);
    assign o_sts.sq_gt      = (r_sq > SQ_W'(r_cand));
    assign o_sts.mod_last   = (r_bit == '0);
    assign o_sts.rem_zero   = (r_rem == '0);

endmodule

@@ hw/rtl/pcr_ctrl.sv @@
// Controller of the prime counter: sequences candidates, divisors and
// remainder steps, and owns the input stall and the output valid.
// Depends on pcr_pkg.
module pcr_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic          i_stall,
    input  pcr_pkg::t_sts i_sts,
    output pcr_pkg::t_cmd o_cmd,
    output logic          o_stall,
    output logic          o_valid
);
    import pcr_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RANGE,
        S_CAND,
        S_TEST,
        S_MOD,
        S_REM,
        S_ADV,
        S_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid & i_stall;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_RANGE;
                end
            end
            S_RANGE: begin
                n_state = i_sts.empty ? S_FINISH : S_CAND;
            end
            S_CAND: begin
                if (i_sts.cand_small) begin
                    n_state = S_ADV;
                end else begin
                    o_cmd.div_init = 1'b1;
                    n_state        = S_TEST;
                end
            end
            S_TEST: begin
                // No divisor up to the square root divided it: prime
                if (i_sts.sq_gt) begin
                    o_cmd.count_inc = 1'b1;
                    n_state         = S_ADV;
                end else begin
                    o_cmd.mod_init = 1'b1;
                    n_state        = S_MOD;
                end
            end
            S_MOD: begin
                o_cmd.mod_step = 1'b1;
                if (i_sts.mod_last) begin
                    n_state = S_REM;
                end
            end
            S_REM: begin
                if (i_sts.rem_zero) begin
                    n_state = S_ADV;
                end else begin
                    o_cmd.div_next = 1'b1;
                    n_state        = S_TEST;
                end
            end
            S_ADV: begin
                if (i_sts.last_cand) begin
                    n_state = S_FINISH;
                end else begin
                    o_cmd.cand_next = 1'b1;
                    n_state         = S_CAND;
                end
            end
            S_FINISH: begin
                // Hold until the output register is free
                if (!r_out_valid || !i_stall) begin
                    o_cmd.publish = 1'b1;
                    n_out_valid   = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;

endmodule

@@ hw/rtl/prime_count_in_range.sv @@
// Prime counter over an inclusive range by trial division; OP_W operand bits (16 default).
// Per candidate: zero and one are passed over; any other value is tried against divisors
// from 2 upward, bit-serially, until one divides it (composite) or the divisor's square
// exceeds it (prime, counted); an empty range goes straight to the result.
// Throughput: one item at a time; the next item is taken while a result waits.
// Reset: synchronous, active low; clears the controller and the output valid.
module prime_count_in_range #(
    parameter int VALUE_BITS = pcr_pkg::VALUE_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [pcr_pkg::FIELD_W-1:0]  i_range_low,
    input  logic [pcr_pkg::FIELD_W-1:0]  i_range_high,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [pcr_pkg::COUNT_W-1:0]  o_prime_count
);
    import pcr_pkg::*;

    t_cmd cmd;
    t_sts sts;

    pcr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stall (i_stall),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_stall (o_stall),
        .o_valid (o_valid)
    );

    pcr_dp #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_range_low   (i_range_low),
        .i_range_high  (i_range_high),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_prime_count (o_prime_count)
    );

    // A prime is counted only once its square-root bound is passed
    a_count_only_prime: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.count_inc |-> (sts.sq_gt && !sts.cand_small))
        else $error("count advanced without a prime verdict");

    // Busy straight after taking an item
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input not stalled after accept");

    // Never overwrite a result still waiting downstream
    a_publish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.publish |-> (!o_valid || !i_stall))
        else $error("result overwritten while stalled");

    // A published result is presented next cycle
    a_publish_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.publish |=> o_valid)
        else $error("published result not presented");

endmodule

@@ tb/tb_prime_count_in_range.sv @@
// Testbench for prime_count_in_range: drives range items, predicts each prime count
// by trial division and checks every result item in order.
// Depends on pcr_pkg and the prime_count_in_range RTL.
module tb_prime_count_in_range;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int VALUE_BITS  = pcr_pkg::VALUE_BITS_DEF;
    localparam int FIELD_W     = pcr_pkg::FIELD_W;
    localparam int COUNT_W     = pcr_pkg::COUNT_W;
    localparam int CYCLE_LIMIT = 20_000_000;
    localparam int SETTLE_CYC  = 50;
    localparam int HOLD_CYC    = 400;
    localparam int HOLD_AFTER  = 3;
    localparam int TAIL_ITEMS  = 15;
    localparam int RANDOM_ITEMS = 80;
    localparam logic [COUNT_W-1:0] COUNT_SAT = '1;

    typedef struct packed {
        logic [FIELD_W-1:0] low;
        logic [FIELD_W-1:0] high;
    } t_range;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    logic [FIELD_W-1:0]  i_range_low;
    logic [FIELD_W-1:0]  i_range_high;
    logic                o_valid;
    logic                i_stall;
    logic [COUNT_W-1:0]  o_prime_count;

    t_range              ranges_pending[$];
    logic [COUNT_W-1:0]  counts_expected[$];
    int                  mismatches;
    int                  counts_seen;
    int                  cycles;
    int                  hold_left;
    bit                  hold_done;
    bit                  range_taken;
    bit                  quiet_tail;
    int                  gap_left;
    int                  stall_left;
    int                  calm_left;

    prime_count_in_range #(
        .VALUE_BITS(VALUE_BITS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_range_low  (i_range_low),
        .i_range_high (i_range_high),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_prime_count(o_prime_count)
    );

    // Count primes in the inclusive range, operands cut to the configured width
    function automatic logic [COUNT_W-1:0] primes_between(logic [FIELD_W-1:0] lo_in,
                                                          logic [FIELD_W-1:0] hi_in);
        logic [FIELD_W-1:0] width_mask;
        int unsigned lo;
        int unsigned hi;
        int unsigned n;
        int unsigned d;
        int unsigned tally;
        bit          composite;
        width_mask = (VALUE_BITS >= FIELD_W) ? '1 : FIELD_W'((1 << VALUE_BITS) - 1);
        lo = lo_in & width_mask;
        hi = hi_in & width_mask;
        tally = 0;
        if (lo <= hi) begin
            for (n = lo; n <= hi; n++) begin
                if (n > 1) begin
                    composite = 0;
                    for (d = 2; d * d <= n && !composite; d++) begin
                        if (n % d == 0)
                            composite = 1;
                    end
                    if (!composite && tally < COUNT_SAT)
                        tally++;
                end
            end
        end
        return COUNT_W'(tally);
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    task automatic queue_range(input int unsigned lo, input int unsigned hi);
        t_range r;
        r.low  = FIELD_W'(lo);
        r.high = FIELD_W'(hi);
        ranges_pending.push_back(r);
    endtask

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Cycle limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL prime_count_in_range");
            $finish;
        end
    end

    // Sample the input handshake and predict the count of each accepted item
    always @(posedge i_clk) begin
        range_taken <= 1'b0;
        if (i_rst_n && i_valid && !o_stall) begin
            range_taken <= 1'b1;
            counts_expected.push_back(primes_between(i_range_low, i_range_high));
        end
    end

    // Driver: offer the next item, hold it while stalled, idle in bursts
    always @(negedge i_clk) begin
        t_range r;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || range_taken) begin
            quiet_tail <= (ranges_pending.size() < TAIL_ITEMS);
            if (gap_left > 0 && !quiet_tail) begin
                gap_left <= gap_left - 1;
                i_valid  <= 1'b0;
            end else if (ranges_pending.size() > 0) begin
                r = ranges_pending.pop_front();
                i_range_low  <= r.low;
                i_range_high <= r.high;
                i_valid      <= 1'b1;
                if ($urandom_range(0, 5) == 0)
                    gap_left <= $urandom_range(1, 10);
                else
                    gap_left <= 0;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Long hold-off on the result side, counted here
    always @(posedge i_clk) begin
        if (!hold_done && counts_seen == HOLD_AFTER) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYC;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Receiver: stall in random bursts with calm stretches, none in the tail
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_left > 0) begin
            i_stall <= 1'b1;
        end else if (quiet_tail) begin
            i_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_stall    <= 1'b1;
        end else if (calm_left > 0) begin
            calm_left <= calm_left - 1;
            i_stall   <= 1'b0;
        end else if ($urandom_range(0, 19) == 0) begin
            calm_left <= $urandom_range(20, 60);
            i_stall   <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 9);
            i_stall    <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Monitor: compare each accepted count with the oldest prediction
    always @(posedge i_clk) begin
        logic [COUNT_W-1:0] want;
        if (i_rst_n && o_valid && !i_stall) begin
            counts_seen <= counts_seen + 1;
            if (counts_expected.size() == 0) begin
                report_mismatch($sformatf("unexpected count %0d", o_prime_count));
            end else begin
                want = counts_expected.pop_front();
                if (o_prime_count !== want)
                    report_mismatch($sformatf("prime_count %0d, predicted %0d",
                                              o_prime_count, want));
            end
        end
    end

    // Stimulus, reset and end of run
    initial begin
        int unsigned lo;
        int unsigned hi;
        int unsigned pick;
        int          items_total;
        mismatches   = 0;
        counts_seen  = 0;
        cycles       = 0;
        hold_left    = 0;
        hold_done    = 1'b0;
        range_taken  = 1'b0;
        quiet_tail   = 1'b0;
        gap_left     = 0;
        stall_left   = 0;
        calm_left    = 0;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_stall      = 1'b0;
        i_range_low  = '0;
        i_range_high = '0;

        // Directed: zero and one, tiny ranges, empty ranges, the top of the field
        queue_range(0, 0);
        queue_range(1, 1);
        queue_range(0, 1);
        queue_range(2, 2);
        queue_range(0, 2);
        queue_range(4, 4);
        queue_range(3, 10);
        queue_range(5, 3);
        queue_range(1, 0);
        queue_range(65535, 0);
        queue_range(65535, 65535);
        queue_range(65534, 65535);
        queue_range(65521, 65521);
        queue_range(65519, 65535);
        queue_range(0, 100);
        queue_range(0, 1000);
        queue_range(32768, 32800);
        queue_range(16'h5555, 16'h55AA);
        queue_range(16'hAAAA, 16'hAAAA);
        queue_range(16'h00FF, 16'h0FF0);
        queue_range(16'h7FFF, 16'h8001);

        // Random: mostly narrow ranges anywhere, some wider low ones, some empty
        repeat (RANDOM_ITEMS) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                lo = $urandom_range(1, 65535);
                hi = $urandom_range(0, lo - 1);
            end else if (pick <= 2) begin
                lo = $urandom_range(0, 2047);
                hi = lo + $urandom_range(0, 100);
            end else begin
                lo = $urandom_range(0, 65535);
                hi = lo + $urandom_range(0, 15);
                if (hi > 65535)
                    hi = 65535;
            end
            queue_range(lo, hi);
        end
        items_total = ranges_pending.size();

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every result item, then watch for strays
        wait (counts_seen == items_total);
        repeat (SETTLE_CYC) @(posedge i_clk);
        if (counts_expected.size() != 0)
            report_mismatch($sformatf("%0d counts never arrived", counts_expected.size()));

        if (mismatches == 0) begin
            $display("PASS prime_count_in_range");
        end else begin
            $display("FAIL prime_count_in_range");
        end
        $finish;
    end

endmodule
